@@ rtl/ghp_pkg.sv @@
package ghp_pkg;

	localparam int HANDLE_W = 64;
	localparam int GEN_W    = 16;
	localparam int GEN_LSB  = 48;
	localparam int COUNT_W  = 32;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_VALIDATE = 3'd1,
		OP_INC      = 3'd2,
		OP_DEC      = 3'd3,
		OP_RELEASE  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_SLOT  = 3'd1,
		STAT_STALE     = 3'd2,
		STAT_INACTIVE  = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_COUNT_MAX = 3'd5
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;   // request accepted: decode it and read the slot entry
		logic execute;   // update the entry and load the result register
	} ghp_cmd_t;

endpackage

@@ rtl/ghp_ctrl.sv @@
module ghp_ctrl
	import ghp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output ghp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   take;

	// take a request only when idle and the result register is free by the next edge
	assign in_stall = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall));
	assign take     = in_valid && !in_stall;

	assign cmd.capture = take;
	assign cmd.execute = (state_q == ST_EXEC);
	assign out_valid   = out_valid_q;

	// advance between decode/read and read-modify-write
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// hold the result until the receiver takes it
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/ghp_datapath.sv @@
module ghp_datapath
	import ghp_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghp_cmd_t            cmd,
	input  logic [OP_W-1:0]     opcode,
	input  logic [HANDLE_W-1:0] handle,
	output logic [STAT_W-1:0]   status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [COUNT_W-1:0]  count_out,
	output logic                slot_freed
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int LOW_W  = GEN_LSB;

	typedef struct packed {
		logic [GEN_W-1:0]   gen;
		logic               active;
		logic [COUNT_W-1:0] count;
		logic [LINK_W-1:0]  next;
	} entry_t;

	entry_t mem [SLOTS];
	entry_t rd_q;

	// free-list head and high-water count; the latter also marks which entries hold data
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] used_q;
	logic [LINK_W-1:0] head_nxt;
	logic [LINK_W-1:0] used_nxt;

	// decode stage
	logic [LOW_W-1:0]  low;
	logic              low_bad;
	logic              head_nz;
	logic [SLOT_W-1:0] addr;
	logic              bad;
	logic              full;

	op_t               op_s1;
	logic [GEN_W-1:0]  gen_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              bad_s1;
	logic              full_s1;
	logic              fresh_s1;

	// execute stage
	entry_t             ent;
	entry_t             wr_data;
	logic               wr_en;
	logic [LOW_W-1:0]   slot_id;
	logic [COUNT_W-1:0] cnt_dec;
	logic               do_free;
	status_t            st;
	logic [HANDLE_W-1:0] hout;
	logic [COUNT_W-1:0] cnt;
	logic               freed;

	status_t            status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [COUNT_W-1:0] count_q;
	logic               freed_q;

	// decode the request and pick the slot to read
	always_comb begin
		low     = handle[LOW_W-1:0];
		low_bad = (low == '0) || (low > LOW_W'(used_q));
		head_nz = (free_head_q != '0);
		full    = !head_nz && (used_q == LINK_W'(SLOTS));
		bad     = 1'b0;
		addr    = SLOT_W'(low - LOW_W'(1));
		unique case (opcode)
			OP_ALLOC: begin
				addr = head_nz ? SLOT_W'(free_head_q - LINK_W'(1)) : SLOT_W'(used_q);
			end
			OP_VALIDATE, OP_INC, OP_DEC, OP_RELEASE: begin
				bad = low_bad;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1    <= op_t'(opcode);
			gen_s1   <= handle[GEN_LSB +: GEN_W];
			slot_s1  <= addr;
			bad_s1   <= bad;
			full_s1  <= full;
			fresh_s1 <= !head_nz;
			rd_q     <= mem[addr];
		end
		if (wr_en) begin
			mem[slot_s1] <= wr_data;
		end
	end

	// check the entry and work out the update
	always_comb begin
		ent = rd_q;
		// a never-used slot reads as generation zero, inactive
		if (fresh_s1 && (op_s1 == OP_ALLOC)) begin
			ent.gen    = '0;
			ent.active = 1'b0;
		end
		slot_id  = LOW_W'(slot_s1) + LOW_W'(1);
		cnt_dec  = ent.count - COUNT_W'(1);
		st       = STAT_OK;
		hout     = '0;
		cnt      = '0;
		freed    = 1'b0;
		wr_en    = 1'b0;
		wr_data  = ent;
		do_free  = 1'b0;
		head_nxt = free_head_q;
		used_nxt = used_q;
		unique case (op_s1)
			OP_ALLOC: begin
				if (full_s1) begin
					st = STAT_FULL;
				end else begin
					wr_en          = cmd.execute;
					wr_data.active = 1'b1;
					wr_data.count  = COUNT_W'(1);
					wr_data.next   = '0;
					hout           = {ent.gen, slot_id};
					cnt            = COUNT_W'(1);
					if (fresh_s1) begin
						used_nxt = used_q + LINK_W'(1);
					end else begin
						head_nxt = ent.next;
					end
				end
			end
			OP_VALIDATE, OP_INC, OP_DEC, OP_RELEASE: begin
				if (bad_s1) begin
					st = STAT_BAD_SLOT;
				end else if (ent.gen != gen_s1) begin
					st = STAT_STALE;
				end else if (!ent.active) begin
					st = STAT_INACTIVE;
				end else begin
					hout = {ent.gen, slot_id};
					priority if (op_s1 == OP_VALIDATE) begin
						cnt = ent.count;
					end else if (op_s1 == OP_INC) begin
						if (ent.count == '1) begin
							st   = STAT_COUNT_MAX;
							hout = '0;
							cnt  = ent.count;
						end else begin
							cnt           = ent.count + COUNT_W'(1);
							wr_en         = cmd.execute;
							wr_data.count = cnt;
						end
					end else if (op_s1 == OP_DEC) begin
						cnt           = cnt_dec;
						wr_en         = cmd.execute;
						wr_data.count = cnt_dec;
						do_free       = (cnt_dec == '0);
					end else begin
						cnt     = cnt_dec;
						do_free = 1'b1;
					end
				end
			end
			default: begin
				st = STAT_BAD_SLOT;
			end
		endcase
		// drop the slot: bump its generation and push it on the free list
		if (do_free) begin
			wr_en          = cmd.execute;
			wr_data.gen    = ent.gen + GEN_W'(1);
			wr_data.active = 1'b0;
			wr_data.count  = '0;
			wr_data.next   = free_head_q;
			head_nxt       = LINK_W'(slot_s1) + LINK_W'(1);
			freed          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			used_q      <= '0;
		end else if (cmd.execute) begin
			free_head_q <= head_nxt;
			used_q      <= used_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= st;
			handle_q <= hout;
			count_q  <= cnt;
			freed_q  <= freed;
		end
	end

	assign status     = status_q;
	assign handle_out = handle_q;
	assign count_out  = count_q;
	assign slot_freed = freed_q;

endmodule

@@ rtl/generational_handle_pool_unit.sv @@
// Generational handle pool.
// Request channel (in_valid / in_stall): opcode and a 64-bit handle, taken at
// a rising edge with in_valid high and in_stall low. Opcodes: allocate,
// validate, increment, decrement, force release.
// Result channel (out_valid / out_stall): status, handle_out, count_out and
// slot_freed, one result for every request, held stable while out_stall is high.
// For each request, the edge that accepts it reads the slot entry from the
// single-port slot memory, and the next edge checks it, writes it back and
// loads the result register. out_valid rises with that load, and a new request
// is taken only after the previous one has been written back.
// While a result waits behind out_stall, the next request is still taken if
// the result is taken by then; otherwise in_stall stays high.
// Reset (arst_n low) empties the free list and the high-water count at once; no
// memory sweep follows, since entries above the high-water count read as fresh.
// SLOTS sets the capacity in slots.
module generational_handle_pool_unit
	import ghp_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [HANDLE_W-1:0] handle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [COUNT_W-1:0]  count_out,
	output logic                slot_freed
);

	ghp_cmd_t cmd;

	ghp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ghp_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.handle     (handle),
		.status     (status),
		.handle_out (handle_out),
		.count_out  (count_out),
		.slot_freed (slot_freed)
	);

endmodule

@@ dv/generational_handle_pool_unit_tb.sv @@
`timescale 1ns / 100ps

module generational_handle_pool_unit_tb;
	import ghp_pkg::*;

	localparam int SLOTS = 256;

	// opcodes outside the defined set
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	// idling schemes for the two channels
	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
		logic                freed;
	} pool_result_t;

	// pool tracker: mirrors the slot table and queues the results it predicts
	class pool_scoreboard;
		logic [GEN_W-1:0]    gen_of  [SLOTS];
		logic [COUNT_W-1:0]  refs_of [SLOTS];
		bit                  live    [SLOTS];
		int                  link_of [SLOTS];
		int                  free_head;
		int                  high_water;
		pool_result_t        pending_results[$];
		int                  status_seen[8];
		int                  errors;
		int                  checked;
		int                  wraps;

		function new();
			foreach (gen_of[s]) begin
				gen_of[s]  = '0;
				refs_of[s] = '0;
				live[s]    = 1'b0;
				link_of[s] = 0;
			end
			foreach (status_seen[k])
				status_seen[k] = 0;
			free_head  = 0;
			high_water = 0;
			errors     = 0;
			checked    = 0;
			wraps      = 0;
		endfunction

		function logic [HANDLE_W-1:0] handle_of(int s);
			return {gen_of[s], GEN_LSB'(s + 1)};
		endfunction

		// bump the generation, drop the slot and push it on the free list
		function void retire(int s);
			gen_of[s] = gen_of[s] + 1'b1;
			if (gen_of[s] == '0)
				wraps++;
			live[s]    = 1'b0;
			refs_of[s] = '0;
			link_of[s] = free_head;
			free_head  = s + 1;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h);
			pool_result_t       r;
			logic [GEN_LSB-1:0] low;
			logic [COUNT_W-1:0] c;
			int                 s;
			r = '0;
			r.status = STAT_OK;
			s = 0;
			case (op)
			OP_ALLOC: begin
				if (free_head != 0) begin
					s = free_head - 1;
					free_head = link_of[s];
				end else if (high_water < SLOTS) begin
					s = high_water;
					high_water++;
				end else begin
					r.status = STAT_FULL;
				end
				if (r.status == STAT_OK) begin
					live[s]    = 1'b1;
					refs_of[s] = 1;
					link_of[s] = 0;
					r.handle   = handle_of(s);
					r.count    = 1;
				end
			end
			OP_VALIDATE, OP_INC, OP_DEC, OP_RELEASE: begin
				// check slot range, then generation, then the active mark
				low = h[GEN_LSB-1:0];
				if (low == '0 || low > GEN_LSB'(high_water)) begin
					r.status = STAT_BAD_SLOT;
				end else begin
					s = int'(low) - 1;
					if (gen_of[s] != h[HANDLE_W-1:GEN_LSB])
						r.status = STAT_STALE;
					else if (!live[s])
						r.status = STAT_INACTIVE;
				end
				if (r.status == STAT_OK) begin
					c = refs_of[s];
					r.handle = handle_of(s);
					case (op)
					OP_VALIDATE: r.count = c;
					OP_INC: begin
						if (c == '1) begin
							r.status = STAT_COUNT_MAX;
							r.handle = '0;
							r.count  = c;
						end else begin
							refs_of[s] = c + 1'b1;
							r.count    = c + 1'b1;
						end
					end
					OP_DEC: begin
						r.count    = c - 1'b1;
						refs_of[s] = r.count;
						if (r.count == '0) begin
							retire(s);
							r.freed = 1'b1;
						end
					end
					default: begin
						r.count = c - 1'b1;
						retire(s);
						r.freed = 1'b1;
					end
					endcase
				end
			end
			default: r.status = STAT_BAD_SLOT;
			endcase
			status_seen[r.status]++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic [HANDLE_W-1:0] h,
			logic [COUNT_W-1:0] c, logic f);
			pool_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status %0d handle %h count %0d freed %0b",
					$time, st, h, c, f);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (st !== want.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
			end
			if (h !== want.handle) begin
				errors++;
				$display("%0t: handle_out expected %h actual %h", $time, want.handle, h);
			end
			if (c !== want.count) begin
				errors++;
				$display("%0t: count_out expected %0d actual %0d", $time, want.count, c);
			end
			if (f !== want.freed) begin
				errors++;
				$display("%0t: slot_freed expected %0b actual %0b", $time, want.freed, f);
			end
		endfunction

		function bit clean();
			return errors == 0 && pending_results.size() == 0;
		endfunction
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     opcode     = '0;
	logic [HANDLE_W-1:0] handle     = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [HANDLE_W-1:0] handle_out;
	logic [COUNT_W-1:0]  count_out;
	logic                slot_freed;

	pool_scoreboard sb;
	int             idle_mode = IDLE_NONE;

	generational_handle_pool_unit #(
		.SLOTS(SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.handle    (handle),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.handle_out(handle_out),
		.count_out (count_out),
		.slot_freed(slot_freed)
	);

	always #5 clk = ~clk;

	function automatic bit sender_pause();
		case (idle_mode)
		IDLE_SENDER: return $urandom_range(99) < 50;
		IDLE_BOTH:   return $urandom_range(99) < 11;
		default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
		IDLE_RECEIVER: return $urandom_range(99) < 50;
		IDLE_BOTH:     return $urandom_range(99) < 11;
		default:       return 1'b0;
		endcase
	endfunction

	function automatic logic [HANDLE_W-1:0] hnd(input logic [GEN_W-1:0] g,
		input logic [GEN_LSB-1:0] n);
		return {g, n};
	endfunction

	// take results and stall the result channel at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, handle_out, count_out, slot_freed);
		out_stall <= receiver_stall();
	end

	// hold the request until the block takes it, then idle at random
	task automatic send(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
		in_valid <= 1'b1;
		opcode   <= op;
		handle   <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, h);
		if (sender_pause()) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (sender_pause())
				@(posedge clk);
		end
	endtask

	// hold off new requests until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed requests on live handles, the rest stale, idle, bad or noise
	task automatic pick_request(input int alloc_pct, input bit filling,
		output logic [OP_W-1:0] op, output logic [HANDLE_W-1:0] h);
		int                 live_q[$];
		int                 idle_q[$];
		int                 r;
		int                 s;
		logic [GEN_LSB-1:0] low;
		for (int k = 0; k < sb.high_water; k++) begin
			if (sb.live[k])
				live_q.push_back(k);
			else
				idle_q.push_back(k);
		end
		op = OP_ALLOC;
		h  = {$urandom, $urandom};
		if ($urandom_range(99) < alloc_pct)
			return;
		r = $urandom_range(99);
		if (r < 75 && live_q.size() != 0) begin
			s = live_q[$urandom_range(live_q.size() - 1)];
			h = sb.handle_of(s);
			r = $urandom_range(99);
			if (filling)
				op = (r < 50) ? OP_VALIDATE : OP_INC;
			else if (r < 20)
				op = OP_VALIDATE;
			else if (r < 50)
				op = OP_INC;
			else if (r < 85)
				op = OP_DEC;
			else
				op = OP_RELEASE;
		end else if (r < 85 && sb.high_water != 0) begin
			s  = $urandom_range(sb.high_water - 1);
			h  = {sb.gen_of[s] + GEN_W'($urandom_range(65535, 1)), GEN_LSB'(s + 1)};
			op = OP_W'($urandom_range(int'(OP_RELEASE), int'(OP_VALIDATE)));
		end else if (r < 90 && idle_q.size() != 0) begin
			h  = sb.handle_of(idle_q[$urandom_range(idle_q.size() - 1)]);
			op = OP_W'($urandom_range(int'(OP_RELEASE), int'(OP_VALIDATE)));
		end else if (r < 95) begin
			case ($urandom_range(3))
			0:       low = '0;
			1:       low = GEN_LSB'(sb.high_water + 1);
			2:       low = '1;
			default: low = GEN_LSB'({$urandom, $urandom}) | GEN_LSB'(32'h0001_0000);
			endcase
			h  = {GEN_W'($urandom), low};
			op = OP_W'($urandom_range(int'(OP_RELEASE), int'(OP_VALIDATE)));
		end else begin
			op = OP_W'($urandom_range(int'(OP_SPARE_LAST), int'(OP_ALLOC)));
		end
	endtask

	task automatic run_phase(input int mode, input int items, input int alloc_pct,
		input bit filling);
		logic [OP_W-1:0]     op;
		logic [HANDLE_W-1:0] h;
		idle_mode = mode;
		repeat (items) begin
			pick_request(alloc_pct, filling, op, h);
			send(op, h);
		end
		drain();
	endtask

	initial begin
		int spin;
		sb = new();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pool, counting, stale and inactive handles, free-list reuse
		send(OP_VALIDATE, '0);
		send(OP_INC, '1);
		send(OP_ALLOC, '1);
		send(OP_ALLOC, '0);
		send(OP_VALIDATE, hnd(0, 1));
		send(OP_INC, hnd(0, 1));
		send(OP_INC, hnd(0, 1));
		send(OP_VALIDATE, hnd('1, 2));
		send(OP_DEC, hnd(0, 3));
		send(OP_DEC, hnd(0, 1));
		send(OP_RELEASE, hnd(0, 1));
		send(OP_VALIDATE, hnd(0, 1));
		send(OP_INC, hnd(1, 1));
		send(OP_DEC, hnd(0, 2));
		send(OP_RELEASE, hnd(1, 2));
		send(OP_ALLOC, '0);
		send(OP_ALLOC, '0);
		send(OP_ALLOC, '0);
		for (int k = int'(OP_SPARE_FIRST); k <= int'(OP_SPARE_LAST); k++)
			send(OP_W'(k), hnd(1, 1));
		send(OP_VALIDATE, hnd(1, 48'h8000_0000_0001));
		send(OP_RELEASE, hnd(1, 2));
		send(OP_DEC, hnd(1, 2));
		drain();

		// random traffic: mixed, fill to exhaustion, drain back, mixed
		run_phase(IDLE_NONE, 200, 35, 1'b0);
		run_phase(IDLE_SENDER, 300, 92, 1'b1);
		run_phase(IDLE_RECEIVER, 175, 15, 1'b0);
		run_phase(IDLE_BOTH, 175, 45, 1'b0);

		// let the last results arrive, then watch for strays
		idle_mode = IDLE_NONE;
		in_valid <= 1'b0;
		spin = 0;
		while (sb.pending_results.size() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		repeat (10)
			@(posedge clk);

		$display("%0d results checked: %0d ok, %0d bad slot, %0d stale, %0d inactive, %0d full",
			sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_BAD_SLOT],
			sb.status_seen[STAT_STALE], sb.status_seen[STAT_INACTIVE],
			sb.status_seen[STAT_FULL]);
		$display("%0d generation wraps, %0d of %0d slots handed out at peak",
			sb.wraps, sb.high_water, SLOTS);
		if (sb.clean())
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#(20_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
